[hw/rtl/upd_pkg.sv]
package upd_pkg;

    // Token length limit and the byte counter that saturates at it
    localparam int MAX_TOKEN_BYTES = 255;
    localparam int CNT_W           = $clog2(MAX_TOKEN_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKEN_BYTES);

    // Results per item and the result queue that holds them
    localparam int MAX_RESULTS = 3;
    localparam int RES_N_W     = $clog2(MAX_RESULTS + 1);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // Characters with a meaning in the token
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    typedef struct packed {
        logic [7:0] data;
        logic       valid_byte;
        logic       part;
        logic       run_last;
        logic       token_end;
    } t_result;

    typedef struct packed {
        logic [RES_N_W-1:0] push_n;
        logic               pop;
    } t_q_ctrl;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_D0 && c <= CH_D9) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= CH_D0 && c <= CH_D9) begin
            t = c - CH_D0;
        end else if (c >= CH_LA && c <= CH_LF) begin
            t = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UF) begin
            t = c - CH_UA + 8'd10;
        end
        return t[3:0];
    endfunction

    // Two escape characters read as base 16: leading white space, one
    // optional sign, then hex digits; no digit gives zero
    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] val;
        logic       neg;
        val = 8'h00;
        neg = 1'b0;
        if (is_space(a)) begin
            if (!is_space(b) && is_hex(b)) begin
                val = {4'h0, hex_val(b)};
            end
        end else if (a == CH_PLUS || a == CH_MINUS) begin
            neg = (a == CH_MINUS);
            if (is_hex(b)) begin
                val = {4'h0, hex_val(b)};
            end
        end else if (is_hex(a)) begin
            if (is_hex(b)) begin
                val = {hex_val(a), hex_val(b)};
            end else begin
                val = {4'h0, hex_val(a)};
            end
        end
        return neg ? (8'h00 - val) : val;
    endfunction

endpackage

[hw/rtl/url_path_percent_decoder.sv]
// URL path percent decoder. Takes a request-target token one byte per item
// (i_in_byte, with i_in_last on its final byte) and returns result items one
// per cycle while i_out_stall is low: path bytes decoded ('+' to space, '%'
// plus two bytes to one byte in strtol base-16 style), query bytes after the
// first '?' passed raw with o_out_part set, a '/' for an empty path, and a
// literal '%' for an escape cut short by '?' or the token end. o_out_run_last
// marks the last result of an input item and o_out_token_end the last result
// of the token; an item that yields no data on the token end gives one bare
// end marker (o_out_valid_byte low). Bytes beyond the first 255 of a token
// yield no data of their own. An item is held in the input register and
// decoded into a four-entry result queue, from whose head its results are
// offered on the output. An item yields at most two results (a cut escape
// with its held byte). Items are taken one per cycle as long as the result
// side keeps up; the queue drains one result per cycle while i_out_stall is
// low, so two-result items first fill the queue and, once it is full, hold
// the input back. Reset needs no clearing pass.
module url_path_percent_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_in_stall,
    // result channel
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid_byte,
    output logic       o_out_part,
    output logic       o_out_run_last,
    output logic       o_out_token_end,
    input  logic       i_out_stall
);

    localparam int NCAND = 5;   // step byte, cut '%', held byte, '/', end marker

    // Input register
    logic                          r_in_valid;
    logic [7:0]                    r_in_byte;
    logic                          r_in_last;

    // Token state
    logic                          r_query;
    logic [1:0]                    r_pend;
    logic [7:0]                    r_held;
    logic                          r_nonempty;
    logic [upd_pkg::CNT_W-1:0]     r_cnt;

    logic                          n_query;
    logic [1:0]                    n_pend;
    logic [7:0]                    n_held;
    logic                          n_nonempty;
    logic [upd_pkg::CNT_W-1:0]     n_cnt;

    upd_pkg::t_result [upd_pkg::MAX_RESULTS-1:0] res;
    logic [upd_pkg::RES_N_W-1:0]   res_n;

    upd_pkg::t_q_ctrl              q_ctrl;
    upd_pkg::t_result              q_head;
    logic [upd_pkg::QCNT_W-1:0]    q_count;
    logic                          pop;
    logic                          fits;
    logic                          advance;

    // Decode one item: gather candidate results in order, then pack
    always_comb begin
        upd_pkg::t_result cand [NCAND];
        logic             cand_en [NCAND];
        logic             take;
        logic             end_q;
        logic             do_end;
        logic             step_en;
        logic             pct_en;
        logic             held_en;
        logic             slash_en;
        logic [upd_pkg::RES_N_W-1:0] k;

        for (int i = 0; i < NCAND; i++) begin
            cand[i]    = '0;
            cand_en[i] = 1'b0;
        end
        n_query    = r_query;
        n_pend     = r_pend;
        n_held     = r_held;
        n_nonempty = r_nonempty;
        n_cnt      = r_cnt;
        end_q      = 1'b0;
        step_en    = 1'b0;

        take = (r_cnt < upd_pkg::CNT_MAX);
        if (take) begin
            n_cnt = r_cnt + 1'b1;
            if (r_query) begin
                step_en        = 1'b1;
                cand[0].data   = r_in_byte;
                cand[0].part   = 1'b1;
            end else if (r_in_byte == upd_pkg::CH_QMARK) begin
                end_q = 1'b1;
            end else begin
                case (r_pend)
                    2'd0: begin
                        if (r_in_byte == upd_pkg::CH_PCT) begin
                            n_pend = 2'd1;
                        end else begin
                            step_en      = 1'b1;
                            cand[0].data = (r_in_byte == upd_pkg::CH_PLUS) ?
                                           upd_pkg::CH_SPACE : r_in_byte;
                        end
                    end
                    2'd1: begin
                        n_held = r_in_byte;
                        n_pend = 2'd2;
                    end
                    default: begin
                        step_en      = 1'b1;
                        cand[0].data = upd_pkg::decode_pair(r_held, r_in_byte);
                        n_pend       = 2'd0;
                    end
                endcase
            end
        end
        cand[0].valid_byte = 1'b1;
        cand_en[0]         = step_en;
        if (step_en && !cand[0].part) begin
            n_nonempty = 1'b1;
        end

        // Close the path: cut escape first, then '/' for an empty path
        do_end   = end_q || (r_in_last && !r_query);
        pct_en   = do_end && (n_pend != 2'd0);
        held_en  = do_end && (n_pend == 2'd2);
        slash_en = do_end && !(n_nonempty || pct_en);

        cand[1].data       = upd_pkg::CH_PCT;
        cand[1].valid_byte = 1'b1;
        cand_en[1]         = pct_en;
        cand[2].data       = (n_held == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : n_held;
        cand[2].valid_byte = 1'b1;
        cand_en[2]         = held_en;
        cand[3].data       = upd_pkg::CH_SLASH;
        cand[3].valid_byte = 1'b1;
        cand_en[3]         = slash_en;
        cand_en[4]         = r_in_last && !(step_en || pct_en || held_en || slash_en);

        if (do_end) begin
            n_pend     = 2'd0;
            n_nonempty = 1'b1;
        end
        if (end_q) begin
            n_query = 1'b1;
        end

        // Pack enabled candidates
        res = '0;
        k   = '0;
        for (int i = 0; i < NCAND; i++) begin
            if (cand_en[i]) begin
                res[k] = cand[i];
                k      = k + 1'b1;
            end
        end
        res_n = k;

        for (int j = 0; j < upd_pkg::MAX_RESULTS; j++) begin
            if (res_n != '0 && upd_pkg::RES_N_W'(j) == res_n - 1'b1) begin
                res[j].run_last  = 1'b1;
                res[j].token_end = r_in_last;
            end
        end

        // Token end: drop all state back to reset
        if (r_in_last) begin
            n_query    = 1'b0;
            n_pend     = 2'd0;
            n_held     = 8'h00;
            n_nonempty = 1'b0;
            n_cnt      = '0;
        end
    end

    // Advance only when the queue has room for every result of this item
    assign pop  = o_out_valid && !i_out_stall;
    assign fits = ((upd_pkg::QCNT_W+1)'(q_count) + (upd_pkg::QCNT_W+1)'(res_n)) <=
                  ((upd_pkg::QCNT_W+1)'(upd_pkg::QDEPTH) + (upd_pkg::QCNT_W+1)'(pop));
    assign advance    = r_in_valid && fits;
    assign o_in_stall = r_in_valid && !fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Hold the payload while stalled, load it on accept
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query    <= 1'b0;
            r_pend     <= 2'd0;
            r_held     <= 8'h00;
            r_nonempty <= 1'b0;
            r_cnt      <= '0;
        end else if (advance) begin
            r_query    <= n_query;
            r_pend     <= n_pend;
            r_held     <= n_held;
            r_nonempty <= n_nonempty;
            r_cnt      <= n_cnt;
        end
    end

    assign q_ctrl.push_n = advance ? res_n : '0;
    assign q_ctrl.pop    = pop;

    upd_result_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (q_ctrl),
        .i_entries (res),
        .o_head    (q_head),
        .o_count   (q_count)
    );

    assign o_out_valid      = (q_count != '0);
    assign o_out_byte       = q_head.data;
    assign o_out_valid_byte = q_head.valid_byte;
    assign o_out_part       = q_head.part;
    assign o_out_run_last   = q_head.run_last;
    assign o_out_token_end  = q_head.token_end;

endmodule

[hw/rtl/upd_result_queue.sv]
module upd_result_queue (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  upd_pkg::t_q_ctrl                              i_ctrl,
    input  upd_pkg::t_result [upd_pkg::MAX_RESULTS-1:0]   i_entries,
    output upd_pkg::t_result                              o_head,
    output logic [upd_pkg::QCNT_W-1:0]                    o_count
);

    upd_pkg::t_result                 r_mem [upd_pkg::QDEPTH];
    logic [upd_pkg::QPTR_W-1:0]       r_wr;
    logic [upd_pkg::QPTR_W-1:0]       r_rd;
    logic [upd_pkg::QCNT_W-1:0]       r_count;

    // Write the first push_n entries at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < upd_pkg::MAX_RESULTS; k++) begin
            if (upd_pkg::RES_N_W'(k) < i_ctrl.push_n) begin
                r_mem[r_wr + upd_pkg::QPTR_W'(k)] <= i_entries[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + upd_pkg::QPTR_W'(i_ctrl.push_n);
            r_rd    <= r_rd + upd_pkg::QPTR_W'(i_ctrl.pop);
            r_count <= r_count + upd_pkg::QCNT_W'(i_ctrl.push_n)
                       - upd_pkg::QCNT_W'(i_ctrl.pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

[hw/rtl/upd_checker.sv]
module upd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic [7:0] o_out_byte,
    input logic       o_out_valid_byte,
    input logic       o_out_part,
    input logic       o_out_run_last,
    input logic       o_out_token_end,
    input logic       i_out_stall
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) &&
        $stable(o_out_valid_byte) && $stable(o_out_part) &&
        $stable(o_out_run_last) && $stable(o_out_token_end))
        else $error("stalled result changed");

    // A bare end marker is empty and closes the token
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_valid_byte |->
        o_out_byte == 8'h00 && !o_out_part && o_out_run_last && o_out_token_end)
        else $error("malformed end marker");

    // The token end is always the last result of its item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_token_end |-> o_out_run_last)
        else $error("token end before run end");

    // Query results always carry data
    a_query_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_part |-> o_out_valid_byte)
        else $error("query result without data");

    // The input stalls only while results are waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind url_path_percent_decoder upd_checker u_upd_checker (.*);
